### rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types and constants shared by the HTTP request head parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

    localparam int NUM_VERBS = 8;
    localparam int VERB_MAX  = 8;

    typedef enum logic [3:0] {
        PH_METHOD    = 4'd0,
        PH_GAP1      = 4'd1,
        PH_URI       = 4'd2,
        PH_GAP2      = 4'd3,
        PH_VERSION   = 4'd4,
        PH_REQ_EOL   = 4'd5,
        PH_LINE      = 4'd6,
        PH_KEY       = 4'd7,
        PH_VALUE     = 4'd8,
        PH_FIELD_EOL = 4'd9,
        PH_HEAD_EOL  = 4'd10,
        PH_BODY      = 4'd11,
        PH_ERROR     = 4'd12
    } phase_t;

    typedef enum logic [3:0] {
        CL_METHOD  = 4'd0,
        CL_GAP     = 4'd1,
        CL_URI     = 4'd2,
        CL_VERSION = 4'd3,
        CL_BREAK   = 4'd4,
        CL_KEY     = 4'd5,
        CL_COLON   = 4'd6,
        CL_VALUE   = 4'd7,
        CL_BODY    = 4'd8,
        CL_ERROR   = 4'd9
    } field_class_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_METHOD  = 3'd1,
        EV_URI     = 3'd2,
        EV_VERSION = 3'd3,
        EV_FIELD   = 3'd4,
        EV_HEADEND = 3'd5,
        EV_ERROR   = 3'd6
    } event_t;

    localparam logic [3:0] CODE_UNKNOWN = 4'd8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Method spellings, zero padded, in method code order
    localparam logic [7:0] VERB_TEXT [NUM_VERBS][VERB_MAX] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] VERB_LEN [NUM_VERBS] = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5
    };

endpackage

`default_nettype wire

### rtl/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// http_request_head_parser
// Tags each request byte with its role and reports parse events.
// ----------------------------------------------------------------------------
// One byte enters per cycle on the slave stream and leaves on the master stream
// after passing through the input register and then the result register;
// the state machine between them classifies one byte per
// cycle, so the sustained rate is one byte per clock while the master side
// takes beats. Backpressure from the master side stalls both registers, and a
// new beat is still taken while a finished result waits if the input register
// is empty. Set tuser on the first byte of a request to restart the
// parser in method phase; after a malformed byte it tags everything as error
// until that restart.
`default_nettype none

module http_request_head_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic [0:0]  s_axis_tuser,   // new_request
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // byte_out
    output logic [10:0]      m_axis_tuser    // field_class, event_res, method_code
);

    import hrhp_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_new_reg;

    // Parser state
    phase_t     phase_reg, phase_next;
    logic [7:0] mask_reg, mask_next;
    logic [2:0] len_reg, len_next;
    logic       lbs_reg, lbs_next;
    logic       err_reg, err_next;

    // Result register
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    field_class_t out_class_reg, out_class_next;
    event_t       out_event_reg, out_event_next;
    logic [3:0]   out_code_reg, out_code_next;

    // Working values
    phase_t     cur_phase;
    logic [7:0] cur_mask;
    logic [2:0] cur_len;
    logic       cur_lbs;
    logic [7:0] b;
    logic       fail;
    logic       found;
    logic [3:0] fin_code;
    logic       advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_code_reg, out_event_reg, out_class_reg};

    always_comb
    begin
        cur_phase = in_new_reg ? PH_METHOD : phase_reg;
        cur_mask  = in_new_reg ? 8'hFF : mask_reg;
        cur_len   = in_new_reg ? 3'd0 : len_reg;
        cur_lbs   = in_new_reg ? 1'b0 : lbs_reg;
        b         = in_byte_reg;

        phase_next = cur_phase;
        mask_next  = cur_mask;
        len_next   = cur_len;
        lbs_next   = cur_lbs;
        err_next   = in_new_reg ? 1'b0 : err_reg;

        out_class_next = CL_ERROR;
        out_event_next = EV_NONE;
        out_code_next  = CODE_UNKNOWN;
        fail           = 1'b0;

        // First surviving method whose length matches the bytes seen
        found    = 1'b0;
        fin_code = CODE_UNKNOWN;
        for (int m = 0; m < NUM_VERBS; m++)
        begin
            if (!found && cur_mask[m] && VERB_LEN[m] == cur_len)
            begin
                found    = 1'b1;
                fin_code = {1'b0, m[2:0]};
            end
        end

        case (cur_phase)
            PH_METHOD:
            begin
                if (b != CH_SPACE)
                begin
                    out_class_next = CL_METHOD;
                    for (int m = 0; m < NUM_VERBS; m++)
                    begin
                        if (cur_len >= VERB_LEN[m] || VERB_TEXT[m][cur_len] != b)
                            mask_next[m] = 1'b0;
                    end
                    if (cur_len != 3'd7)
                        len_next = cur_len + 3'd1;
                end
                else if (!found)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    out_class_next = CL_GAP;
                    out_event_next = EV_METHOD;
                    out_code_next  = fin_code;
                    phase_next     = PH_GAP1;
                end
            end
            PH_GAP1:
            begin
                if (b == CH_SPACE)
                    out_class_next = CL_GAP;
                else
                begin
                    out_class_next = CL_URI;
                    phase_next     = PH_URI;
                end
            end
            PH_URI:
            begin
                if (b == CH_SPACE)
                begin
                    out_class_next = CL_GAP;
                    out_event_next = EV_URI;
                    phase_next     = PH_GAP2;
                end
                else
                    out_class_next = CL_URI;
            end
            PH_GAP2, PH_VERSION:
            begin
                if (b == CH_CR)
                begin
                    out_class_next = CL_BREAK;
                    out_event_next = EV_VERSION;
                    lbs_next       = 1'b1;
                    phase_next     = PH_REQ_EOL;
                end
                else if (b == CH_SPACE)
                begin
                    if (cur_phase == PH_GAP2)
                        out_class_next = CL_GAP;
                    else
                        fail = 1'b1;
                end
                else
                begin
                    out_class_next = CL_VERSION;
                    phase_next     = PH_VERSION;
                end
            end
            PH_REQ_EOL, PH_FIELD_EOL, PH_HEAD_EOL:
            begin
                if (!cur_lbs)
                begin
                    if (b == CH_CR)
                    begin
                        out_class_next = CL_BREAK;
                        lbs_next       = 1'b1;
                    end
                    else
                        fail = 1'b1;
                end
                else if (b == CH_LF)
                begin
                    out_class_next = CL_BREAK;
                    lbs_next       = 1'b0;
                    if (cur_phase == PH_HEAD_EOL)
                    begin
                        out_event_next = EV_HEADEND;
                        phase_next     = PH_BODY;
                    end
                    else
                        phase_next = PH_LINE;
                end
                else
                    fail = 1'b1;
            end
            PH_LINE:
            begin
                if (b == CH_CR)
                begin
                    out_class_next = CL_BREAK;
                    lbs_next       = 1'b1;
                    phase_next     = PH_HEAD_EOL;
                end
                else if (b == CH_COLON)
                begin
                    out_class_next = CL_COLON;
                    phase_next     = PH_VALUE;
                end
                else
                begin
                    out_class_next = CL_KEY;
                    phase_next     = PH_KEY;
                end
            end
            PH_KEY:
            begin
                if (b == CH_COLON)
                begin
                    out_class_next = CL_COLON;
                    phase_next     = PH_VALUE;
                end
                else
                    out_class_next = CL_KEY;
            end
            PH_VALUE:
            begin
                if (b == CH_CR)
                begin
                    out_class_next = CL_BREAK;
                    out_event_next = EV_FIELD;
                    lbs_next       = 1'b1;
                    phase_next     = PH_FIELD_EOL;
                end
                else
                    out_class_next = CL_VALUE;
            end
            PH_BODY:
            begin
                out_class_next = CL_BODY;
            end
            default:
            begin
                // sticky sink: tag as error, no further events
                out_class_next = CL_ERROR;
                phase_next     = PH_ERROR;
                err_next       = 1'b1;
            end
        endcase

        if (fail)
        begin
            out_class_next = CL_ERROR;
            out_event_next = EV_ERROR;
            out_code_next  = CODE_UNKNOWN;
            phase_next     = PH_ERROR;
            err_next       = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_METHOD;
            mask_reg      <= 8'hFF;
            len_reg       <= 3'd0;
            lbs_reg       <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                phase_reg <= phase_next;
                mask_reg  <= mask_next;
                len_reg   <= len_next;
                lbs_reg   <= lbs_next;
                err_reg   <= err_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_new_reg  <= s_axis_tuser[0];
        end
        if (advance)
        begin
            out_byte_reg  <= in_byte_reg;
            out_class_reg <= out_class_next;
            out_event_reg <= out_event_next;
            out_code_reg  <= out_code_next;
        end
    end

    // Error flag and sink phase always agree
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg == (phase_reg == PH_ERROR))
        else $error("error flag and error phase disagree");

    // A pending LF is only expected in a line break phase or the sink
    a_lbs_phase: assert property (@(posedge clk) disable iff (!rst_n)
        lbs_reg |-> (phase_reg == PH_REQ_EOL || phase_reg == PH_FIELD_EOL ||
                     phase_reg == PH_HEAD_EOL || phase_reg == PH_ERROR))
        else $error("line break step set outside a line break phase");

    // A method event carries a known method, any other result carries none
    a_method_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_event_reg == EV_METHOD) == (out_code_reg != CODE_UNKNOWN)))
        else $error("method code inconsistent with event");

    // Error event comes only with the error tag
    a_err_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == EV_ERROR) |-> out_class_reg == CL_ERROR)
        else $error("error event without error tag");

endmodule

`default_nettype wire
